[rtl/drmf_pkg.sv]
// Shared types and defaults for the dual running median filter.
// No dependencies; imported by every module of the block.
package drmf_pkg;

   // Width of a range field on the request and response channels
   localparam int RANGE_BITS = 16;

   // Default window length and stored sample width
   localparam int WINDOW_LEN_DEF  = 9;
   localparam int SAMPLE_BITS_DEF = 16;

   // One request: a left and a right range sample
   typedef struct packed {
      logic [RANGE_BITS-1:0] left_range_mm;
      logic [RANGE_BITS-1:0] right_range_mm;
   } req_type;

   // One response: held medians and their valid flag
   typedef struct packed {
      logic [RANGE_BITS-1:0] left_distance_mm;
      logic [RANGE_BITS-1:0] right_distance_mm;
      logic                  distance_valid;
   } rsp_type;

endpackage

[rtl/dual_running_median_filter_unit.sv]
// Dual running median filter: top level with window shift lines and output register.
// Depends on drmf_pkg and drmf_median.
//
// Usage:
//   The request channel (req_valid/req_ready/req_data) carries one left and one
//   right range sample per request. Each request yields exactly one response on
//   rsp_valid/rsp_ready/rsp_data, in order.
//   Each channel keeps the last WINDOW_LEN samples in a shift line. Once the
//   window is full, a request reports the median of the window as it stood
//   before that request's sample was shifted in, so results lag by one request.
//   Until the window first fills, both distances read 0 and distance_valid is 0.
//   Samples beyond the stored width saturate to its largest value.
//   The response is registered and is valid in the cycle after its request is accepted.
//   Throughput: one request per cycle while the receiver takes each response, set
//   by the combinational rank network feeding the response register.
//   Reset clears the fill count and the response valid flag; the window contents
//   are not cleared and are never read before they are written.
//   When the receiver stalls, the response holds and req_ready stays high only
//   if that response is taken in the same cycle.
module dual_running_median_filter_unit #(
   parameter int WINDOW_LEN  = drmf_pkg::WINDOW_LEN_DEF,
   parameter int SAMPLE_BITS = drmf_pkg::SAMPLE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  drmf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output drmf_pkg::rsp_type rsp_data
);
   import drmf_pkg::*;

   localparam int FILL_BITS = $clog2(WINDOW_LEN + 1);
   localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(WINDOW_LEN);

   logic                                  req_accept;
   logic                                  window_full;
   logic [FILL_BITS-1:0]                  fill_count_ff, fill_count_in;
   logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] left_win_ff, left_win_in;
   logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] right_win_ff, right_win_in;
   logic [SAMPLE_BITS-1:0]                left_sample, right_sample;
   logic [SAMPLE_BITS-1:0]                left_median, right_median;
   logic [RANGE_BITS-1:0]                 left_out, right_out;
   logic                                  rsp_valid_ff, rsp_valid_in;
   rsp_type                               rsp_data_ff, rsp_data_in;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign req_accept  = req_valid && req_ready;
   assign window_full = (fill_count_ff == FILL_FULL);

   // Saturate incoming samples to the stored width; narrow medians back out
   generate
      if (SAMPLE_BITS >= RANGE_BITS) begin : g_wide
         assign left_sample  = SAMPLE_BITS'(req_data.left_range_mm);
         assign right_sample = SAMPLE_BITS'(req_data.right_range_mm);
         assign left_out     = left_median[RANGE_BITS-1:0];
         assign right_out    = right_median[RANGE_BITS-1:0];
      end else begin : g_narrow
         assign left_sample  = (|req_data.left_range_mm[RANGE_BITS-1:SAMPLE_BITS]) ?
                               '1 : req_data.left_range_mm[SAMPLE_BITS-1:0];
         assign right_sample = (|req_data.right_range_mm[RANGE_BITS-1:SAMPLE_BITS]) ?
                               '1 : req_data.right_range_mm[SAMPLE_BITS-1:0];
         assign left_out     = RANGE_BITS'(left_median);
         assign right_out    = RANGE_BITS'(right_median);
      end
   endgenerate

   // Median of each window as it stands before this request's shift
   drmf_median #(
      .WINDOW_LEN (WINDOW_LEN),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_left_median (
      .window_samples(left_win_ff),
      .median_sample (left_median)
   );

   drmf_median #(
      .WINDOW_LEN (WINDOW_LEN),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_right_median (
      .window_samples(right_win_ff),
      .median_sample (right_median)
   );

   // Shift the new sample in at the top, drop the oldest at the bottom
   always_comb begin
      left_win_in   = left_win_ff;
      right_win_in  = right_win_ff;
      fill_count_in = fill_count_ff;
      if (req_accept) begin
         left_win_in  = {left_sample, left_win_ff[WINDOW_LEN-1:1]};
         right_win_in = {right_sample, right_win_ff[WINDOW_LEN-1:1]};
         if (!window_full) begin
            fill_count_in = fill_count_ff + FILL_BITS'(1);
         end
      end
   end

   // Load the response on accept, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in.left_distance_mm  = window_full ? left_out : '0;
         rsp_data_in.right_distance_mm = window_full ? right_out : '0;
         rsp_data_in.distance_valid    = window_full;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_win_ff  <= left_win_in;
      right_win_ff <= right_win_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/drmf_median.sv]
// Median of one full window, found by ranking every sample against the others.
// Depends on drmf_pkg; purely combinational, instanced once per channel.
module drmf_median #(
   parameter int WINDOW_LEN  = drmf_pkg::WINDOW_LEN_DEF,
   parameter int SAMPLE_BITS = drmf_pkg::SAMPLE_BITS_DEF
) (
   input  logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] window_samples,
   output logic [SAMPLE_BITS-1:0]                 median_sample
);
   import drmf_pkg::*;

   localparam int RANK_BITS = $clog2(WINDOW_LEN);
   localparam logic [RANK_BITS-1:0] RANK_MID = RANK_BITS'(WINDOW_LEN / 2);

   logic [RANK_BITS-1:0] rank [WINDOW_LEN];

   // Rank each sample: count smaller ones, break ties by position
   always_comb begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
         rank[i] = '0;
         for (int j = 0; j < WINDOW_LEN; j++) begin
            if (j != i) begin
               if ((window_samples[j] < window_samples[i]) ||
                   ((window_samples[j] == window_samples[i]) && (j < i))) begin
                  rank[i] = rank[i] + RANK_BITS'(1);
               end
            end
         end
      end
   end

   // Ranks form a permutation, so exactly one sample sits at the middle rank
   always_comb begin
      median_sample = '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         if (rank[i] == RANK_MID) begin
            median_sample = median_sample | window_samples[i];
         end
      end
   end

endmodule

[rtl/drmf_checker.sv]
// Port-level checks for the dual running median filter, bound to the top level.
// Depends on drmf_pkg and dual_running_median_filter_unit.
module drmf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input drmf_pkg::rsp_type rsp_data
);
   import drmf_pkg::*;

   // Reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response pending right after reset");

   // An accepted request shows up as a response in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request produced no response");

   // With no response pending the output register is free for a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused while output register is empty");

   // Before the first median both distances read zero
   a_zero_before_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.distance_valid) |->
      (rsp_data.left_distance_mm == '0) && (rsp_data.right_distance_mm == '0))
      else $error("nonzero distance before window filled");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind dual_running_median_filter_unit drmf_checker u_drmf_checker (.*);

[dv/testbench.sv]
// Self-checking testbench for dual_running_median_filter_unit: per-channel median predictor,
// in-order scoreboard and random valid/ready pressure on both channels.
// Depends on drmf_pkg and the RTL of the block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import drmf_pkg::*;

   localparam int WINDOW       = WINDOW_LEN_DEF;
   localparam int MID_POS      = WINDOW / 2;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 4;

   typedef logic [RANGE_BITS-1:0] range_type;
   typedef logic [WINDOW-1:0][RANGE_BITS-1:0] window_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int fail_count         = 0;
   int requests_sent      = 0;
   int results_checked    = 0;
   int medians_checked    = 0;
   int cycle_count        = 0;
   range_type cluster_base = '0;

   // Predictor state: both windows fill together under one count
   window_type left_win   = '0;
   window_type right_win  = '0;
   int         fill_level = 0;
   range_type  left_held  = '0;
   range_type  right_held = '0;
   rsp_type    pending_medians[$];

   dual_running_median_filter_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Generate the 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the response channel at the current rate
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Sort a copy of the window and pick the middle entry
   function automatic range_type window_median(input window_type win);
      window_type sorted;
      range_type  key;
      int         j;
      sorted = win;
      for (int i = 1; i < WINDOW; i++) begin
         key = sorted[i];
         j   = i - 1;
         while (j >= 0 && sorted[j] > key) begin
            sorted[j+1] = sorted[j];
            j--;
         end
         sorted[j+1] = key;
      end
      return sorted[MID_POS];
   endfunction

   // Advance the predictor by one request and return the response it causes.
   // Samples are already at the stored width, so no saturation can occur.
   function automatic rsp_type compute_held_medians(input req_type req);
      rsp_type result;
      logic    full;
      full = (fill_level >= WINDOW);
      if (full) begin
         // take the median of the window as it stood, then slide it
         left_held  = window_median(left_win);
         right_held = window_median(right_win);
         for (int i = 0; i < WINDOW - 1; i++) begin
            left_win[i]  = left_win[i+1];
            right_win[i] = right_win[i+1];
         end
         left_win[WINDOW-1]  = req.left_range_mm;
         right_win[WINDOW-1] = req.right_range_mm;
      end else begin
         left_win[fill_level]  = req.left_range_mm;
         right_win[fill_level] = req.right_range_mm;
         fill_level++;
      end
      result.left_distance_mm  = left_held;
      result.right_distance_mm = right_held;
      result.distance_valid    = full;
      return result;
   endfunction

   // Check each response against the oldest prediction, then log new requests
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_medians.size() == 0) begin
               $error("response with no request pending: %p", rsp_data);
               fail_count++;
            end else begin
               want = pending_medians.pop_front();
               if (rsp_data.left_distance_mm !== want.left_distance_mm) begin
                  $error("left_distance_mm: expected %0d, actual %0d",
                         want.left_distance_mm, rsp_data.left_distance_mm);
                  fail_count++;
               end
               if (rsp_data.right_distance_mm !== want.right_distance_mm) begin
                  $error("right_distance_mm: expected %0d, actual %0d",
                         want.right_distance_mm, rsp_data.right_distance_mm);
                  fail_count++;
               end
               if (rsp_data.distance_valid !== want.distance_valid) begin
                  $error("distance_valid: expected %0b, actual %0b",
                         want.distance_valid, rsp_data.distance_valid);
                  fail_count++;
               end
               results_checked++;
               if (want.distance_valid) medians_checked++;
            end
         end
         if (req_valid && req_ready) begin
            pending_medians = {pending_medians, compute_held_medians(req_data)};
         end
      end
   end

   // Drive one request, with random idle cycles ahead of it, and hold until taken
   task automatic send_request(input range_type left_mm, input range_type right_mm);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req_type'{left_mm, right_mm};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
   endtask

   // Drop valid and hold until every predicted response has come back
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      // let the last accepted request reach the prediction queue first
      @(posedge clock);
      while (pending_medians.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mix of full-range values, tight clusters (ties), rails and bit patterns
   function automatic range_type random_range_sample();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return range_type'($urandom_range(65535));
         5, 6:          return cluster_base + range_type'($urandom_range(15));
         7:             return $urandom_range(1) ? '1 : '0;
         8:             return range_type'(1) << $urandom_range(RANGE_BITS - 1);
         default:       return ~(range_type'(1) << $urandom_range(RANGE_BITS - 1));
      endcase
   endfunction

   // Fill the window with rail and alternating-bit samples; no median yet
   task automatic test_window_fill();
      send_request(16'h0000, 16'hFFFF);
      send_request(16'hFFFF, 16'h0000);
      send_request(16'hAAAA, 16'h5555);
      send_request(16'h5555, 16'hAAAA);
      send_request(16'h0001, 16'hFFFE);
      send_request(16'hFFFE, 16'h0001);
      send_request(16'h8000, 16'h7FFF);
      send_request(16'h7FFF, 16'h8000);
      send_request(16'd12345, 16'd54321);
   endtask

   // Slide ordered runs through the window, then equal samples and a spike
   task automatic test_median_cases();
      for (int i = 1; i <= 8; i++) begin
         send_request(range_type'(i * 1000), range_type'(65535 - i * 1000));
      end
      repeat (5) send_request(16'd500, 16'd500);
      send_request(16'hFFFF, 16'h0000);
   endtask

   // Stream random samples at the given idle and stall rates
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int count);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         if (n % 32 == 0) cluster_base = range_type'($urandom_range(65535));
         send_request(random_range_sample(), random_range_sample());
      end
   endtask

   // Pause the sender until the pipe is empty, then resume
   task automatic test_drain_pause();
      sender_idle_pct    = 0;
      receiver_stall_pct = 25;
      repeat (20) send_request(random_range_sample(), random_range_sample());
      wait_until_drained();
      repeat (20) send_request(random_range_sample(), random_range_sample());
   endtask

   // End the run if it hangs
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Release reset and run the tests in turn
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_window_fill();
      test_median_cases();
      test_random_traffic(0, 0, 250);
      test_random_traffic(49, 0, 250);
      test_drain_pause();
      test_random_traffic(0, 49, 250);
      test_random_traffic(25, 25, 250);
      wait_until_drained();
      $display("Sent %0d requests; checked %0d responses, %0d of them with a median.",
               requests_sent, results_checked, medians_checked);
      $display("Traffic ran free, with sender gaps, receiver stalls, both, and a full drain.");
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[dual_running_median_filter_unit.f]
rtl/drmf_pkg.sv
rtl/drmf_median.sv
rtl/dual_running_median_filter_unit.sv
rtl/drmf_checker.sv
dv/testbench.sv
